[src/utf8v_pkg.sv]
// shared types and constants for the utf-8 validator
package utf8v_pkg;

   localparam int RULE_W = 3;

   // allowed range for the next continuation byte
   localparam logic [RULE_W-1:0] RULE_ANY = 3'd0;
   localparam logic [RULE_W-1:0] RULE_E0  = 3'd1;
   localparam logic [RULE_W-1:0] RULE_ED  = 3'd2;
   localparam logic [RULE_W-1:0] RULE_F0  = 3'd3;
   localparam logic [RULE_W-1:0] RULE_F4  = 3'd4;
   localparam int RULE_COUNT = 2 ** RULE_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                  is_empty;
      logic                  is_last;
      logic                  lead_bad;
      logic [1:0]            lead_len;
      logic [RULE_W-1:0]     lead_rule;
      logic [RULE_COUNT-1:0] cont_ok;
   } cls_type;

   typedef struct packed {
      logic    valid;
      cls_type item;
   } queue_out_type;

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } queue_stat_type;

endpackage

[src/utf8v_if.sv]
// handshake channels for string bytes and per-string results
interface utf8v_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;
   logic       empty_string;

   modport source (output valid, output data_byte, output is_last, output empty_string,
                   input ready);
   modport sink (input valid, input data_byte, input is_last, input empty_string,
                 output ready);
endinterface

interface utf8v_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, output valid_res, input ready);
   modport sink (input valid, input valid_res, output ready);
endinterface

[src/utf8_validator.sv]
// top level of the streaming utf-8 validator
//
//   channel    dir   beat                                   accepted when
//   req_chan   in    data_byte, is_last, empty_string       valid && ready
//   rsp_chan   out   valid_res, one per string              valid && ready
//
// one byte per cycle sustained unless a result stalls; the last beat of a string
// passes the queue, then the tracker, into the result register
// the tracker state feeds back through its registers and sets the rate
// synchronous reset clears queue pointers, tracker state and result valid
// a stalled result holds the tracker; the two-entry queue absorbs input
module utf8_validator (
   input  logic        clock,
   input  logic        reset,
   utf8v_req_if.sink   req_chan,
   utf8v_rsp_if.source rsp_chan
);
   import utf8v_pkg::*;

   logic           push;
   cls_type        push_item;
   logic           pop;
   queue_out_type  q_out;
   queue_stat_type q_stat;

   utf8v_front u_front (
      .req_chan   (req_chan),
      .queue_full (q_stat.full),
      .push       (push),
      .push_item  (push_item)
   );

   utf8v_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_out     (q_out),
      .q_stat    (q_stat)
   );

   utf8v_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_out    (q_out),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_chan.ready)
      else $error("input not ready after reset");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !q_out.valid |-> !pop)
      else $error("pop from empty queue");
   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !pop)
      else $error("tracker advanced while result stalled");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");
`endif

endmodule

[src/utf8v_front.sv]
// byte classifier: lead length, lead rule and continuation range checks
module utf8v_front (
   utf8v_req_if.sink         req_chan,
   input  logic              queue_full,
   output logic              push,
   output utf8v_pkg::cls_type push_item
);
   import utf8v_pkg::*;

   logic [7:0] b;
   logic       in_cont;

   assign b       = req_chan.data_byte;
   assign in_cont = (b >= 8'h80) && (b <= 8'hbf);

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   always_comb begin
      push_item           = '0;
      push_item.is_empty  = req_chan.empty_string;
      push_item.is_last   = req_chan.is_last;
      push_item.lead_rule = RULE_ANY;
      push_item.lead_len  = 2'd0;
      push_item.lead_bad  = 1'b0;
      priority if (b <= 8'h7f) begin
         push_item.lead_len = 2'd0;
      end else if ((b >= 8'hc2) && (b <= 8'hdf)) begin
         push_item.lead_len = 2'd1;
      end else if ((b >= 8'he0) && (b <= 8'hef)) begin
         push_item.lead_len = 2'd2;
         if (b == 8'he0) begin
            push_item.lead_rule = RULE_E0;
         end else if (b == 8'hed) begin
            push_item.lead_rule = RULE_ED;
         end
      end else if ((b >= 8'hf0) && (b <= 8'hf4)) begin
         push_item.lead_len = 2'd3;
         if (b == 8'hf0) begin
            push_item.lead_rule = RULE_F0;
         end else if (b == 8'hf4) begin
            push_item.lead_rule = RULE_F4;
         end
      end else begin
         push_item.lead_bad = 1'b1;
      end
      // unused rule codes behave as any continuation byte
      push_item.cont_ok          = {RULE_COUNT{in_cont}};
      push_item.cont_ok[RULE_E0] = (b >= 8'ha0) && (b <= 8'hbf);
      push_item.cont_ok[RULE_ED] = (b >= 8'h80) && (b <= 8'h9f);
      push_item.cont_ok[RULE_F0] = (b >= 8'h90) && (b <= 8'hbf);
      push_item.cont_ok[RULE_F4] = (b >= 8'h80) && (b <= 8'h8f);
   end

endmodule

[src/utf8v_fifo.sv]
// short queue of classified beats between front and back
module utf8v_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utf8v_pkg::cls_type         push_item,
   input  logic                       pop,
   output utf8v_pkg::queue_out_type   q_out,
   output utf8v_pkg::queue_stat_type  q_stat
);
   import utf8v_pkg::*;

   cls_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_out.valid  = (count_ff != '0);
   assign q_out.item   = mem_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/utf8v_back.sv]
// sequence tracker and result register
module utf8v_back (
   input  logic                     clock,
   input  logic                     reset,
   input  utf8v_pkg::queue_out_type q_out,
   output logic                     pop,
   utf8v_rsp_if.source              rsp_chan
);
   import utf8v_pkg::*;

   logic [1:0]        pend_ff, pend_in;
   logic [RULE_W-1:0] rule_ff, rule_in;
   logic              err_ff, err_in;
   logic              out_valid_ff, out_valid_in;
   logic              res_ff, res_in;
   cls_type           it;
   logic              ok;

   assign it  = q_out.item;
   assign ok  = it.cont_ok[rule_ff];
   assign pop = q_out.valid && (!out_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.valid_res = res_ff;

   always_comb begin
      pend_in      = pend_ff;
      rule_in      = rule_ff;
      err_in       = err_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (pop) begin
         if (!it.is_empty) begin
            if (pend_ff != 2'd0) begin
               err_in  = err_ff || !ok;
               pend_in = ok ? pend_ff - 2'd1 : 2'd0;
               rule_in = RULE_ANY;
            end else if (it.lead_bad) begin
               err_in = 1'b1;
            end else begin
               pend_in = it.lead_len;
               rule_in = it.lead_rule;
            end
         end
         if (it.is_empty || it.is_last) begin
            res_in       = !err_in && (pend_in == 2'd0);
            out_valid_in = 1'b1;
            pend_in      = 2'd0;
            rule_in      = RULE_ANY;
            err_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'd0;
         rule_ff      <= RULE_ANY;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rule_ff      <= rule_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule
